// ===== rtl/core/running_average_background_subtractor_defines.svh =====
// assertion macros for the running average background subtractor
`ifndef RUNNING_AVERAGE_BACKGROUND_SUBTRACTOR_DEFINES_SVH
`define RUNNING_AVERAGE_BACKGROUND_SUBTRACTOR_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define RABS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property whose consequent is checked in the cycle after the antecedent
`define RABS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rabs_pkg.sv =====
// shared constants and payload types of the background subtractor
package rabs_pkg;

  localparam int NUM_PIXELS_DEF = 16384;
  localparam int WINDOW_DEF     = 64;

  localparam int PIX_W   = 8;
  localparam int IDX_W   = 14;
  localparam int SUM_W   = 16;

  localparam logic [PIX_W-1:0] PIX_MAX         = 8'd255;
  localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd50;

  // output queue depth, also the bound on words in flight
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic [IDX_W-1:0] pixel_index;
    logic             last_of_frame;
  } pix_t;

  typedef struct packed {
    logic [PIX_W-1:0] average_value;
    logic [PIX_W-1:0] difference;
    logic             foreground;
    logic             warming_up;
  } res_t;

  // per-pixel state word: running sum and latched background
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [PIX_W-1:0] bg;
  } state_t;

endpackage

// ===== rtl/core/rabs_if.sv =====
// valid/ready stream interfaces for pixel words and result words
interface rabs_pix_if;
  logic            valid;
  logic            ready;
  rabs_pkg::pix_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rabs_res_if;
  logic            valid;
  logic            ready;
  rabs_pkg::res_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/rabs_ram.sv =====
// generic single write port ram with one registered read port
module rabs_ram #(
  parameter int WIDTH = rabs_pkg::PIX_W,
  parameter int DEPTH = rabs_pkg::NUM_PIXELS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/running_average_background_subtractor.sv =====
// running average background subtractor, state kept in a history ram and a sum ram.
// pipeline: quotient, ram reads, sum update, mean, difference, result queue; one word per
// cycle while the queue has room; the sum ram read-modify-write is forwarded, not stalled.
// after reset a clearing pass zeroes every sum ram word, ready stays low meanwhile.
// reset also clears frame count, ring slot and queues, and sets the threshold to 50.
`include "running_average_background_subtractor_defines.svh"

module running_average_background_subtractor #(
  parameter int NUM_PIXELS = rabs_pkg::NUM_PIXELS_DEF,
  parameter int WINDOW     = rabs_pkg::WINDOW_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rabs_pix_if.sink                   pix_i,
  rabs_res_if.source                 res_o,
  input  logic                       cfg_we_i,
  input  logic [rabs_pkg::PIX_W-1:0] cfg_wdata_i
);

  localparam int PIX_W   = rabs_pkg::PIX_W;
  localparam int IDX_W   = rabs_pkg::IDX_W;
  localparam int SUM_W   = rabs_pkg::SUM_W;
  localparam int STATE_W = $bits(rabs_pkg::state_t);
  localparam int AW      = $clog2(NUM_PIXELS);
  localparam int HDEPTH  = NUM_PIXELS * WINDOW;
  localparam int HAW     = $clog2(HDEPTH);
  localparam int SLOT_W  = $clog2(WINDOW);
  localparam int FC_W    = $clog2(WINDOW + 2);
  localparam int PTR_W   = rabs_pkg::PTR_W;
  localparam int OCC_W   = rabs_pkg::OCC_W;
  localparam int DEPTH   = rabs_pkg::FIFO_DEPTH;

  // index modulo NUM_PIXELS by reciprocal multiply, exact for every IDX_W-bit index
  localparam int     IDX_SH    = IDX_W + $clog2(NUM_PIXELS);
  localparam longint IDX_RCP   = ((longint'(1) << IDX_SH) + longint'(NUM_PIXELS) - 1)
                                 / longint'(NUM_PIXELS);
  localparam int     IDX_RCP_W = IDX_W + 2;

  // sum divided by WINDOW, same scheme
  localparam int     AVG_SH    = SUM_W + $clog2(WINDOW);
  localparam longint AVG_RCP   = ((longint'(1) << AVG_SH) + longint'(WINDOW) - 1)
                                 / longint'(WINDOW);
  localparam int     AVG_RCP_W = SUM_W + 2;

  // ---------------------------------------------------------------- control
  logic                   accept;
  logic                   fifo_push;
  logic                   fifo_pop;
  logic                   fifo_full;
  logic [PIX_W-1:0]       thr_q;
  logic                   clr_busy_q;
  logic [AW-1:0]          clr_cnt_q;
  logic [FC_W-1:0]        frame_q;
  logic [SLOT_W-1:0]      slot_q;
  logic [HAW-1:0]         base_q;
  logic [OCC_W-1:0]       occ_q;
  logic [OCC_W-1:0]       fifo_cnt_q;
  logic [PTR_W-1:0]       wr_ptr_q;
  logic [PTR_W-1:0]       rd_ptr_q;
  logic                   s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  logic [4:0]             stage_vld;
  logic                   fwd_valid_q;

  // ---------------------------------------------------------------- payload
  logic [PIX_W-1:0]             s1_val_q;
  logic [IDX_W-1:0]             s1_idx_q;
  logic [IDX_W-1:0]             s1_quo_q;
  logic                         s1_warm_q, s1_bgwr_q;
  logic [HAW-1:0]               s1_base_q;
  logic [IDX_W+IDX_RCP_W-1:0]   idx_prod;
  logic [IDX_W-1:0]             idx_rem;

  logic [PIX_W-1:0]             s2_val_q;
  logic [AW-1:0]                s2_addr_q;
  logic                         s2_warm_q, s2_bgwr_q;
  logic [HAW-1:0]               s2_base_q;
  logic [HAW-1:0]               hist_addr;

  logic [PIX_W-1:0]             s3_val_q;
  logic [AW-1:0]                s3_addr_q;
  logic                         s3_warm_q, s3_bgwr_q;
  logic [PIX_W-1:0]             hist_rdata;
  rabs_pkg::state_t             state_rdata;
  rabs_pkg::state_t             s3_state;
  logic [SUM_W-1:0]             s3_sum_new;

  logic [SUM_W-1:0]             s4_sum_q;
  logic [PIX_W-1:0]             s4_bg_q;
  logic [AW-1:0]                s4_addr_q;
  logic                         s4_warm_q, s4_bgwr_q;
  logic [SUM_W+AVG_RCP_W-1:0]   avg_prod;
  logic [SUM_W-1:0]             avg_full;
  logic [PIX_W-1:0]             s4_avg;
  rabs_pkg::state_t             s4_state;

  logic [AW-1:0]                fwd_addr_q;
  rabs_pkg::state_t             fwd_data_q;

  logic [PIX_W-1:0]             s5_avg_q;
  logic [PIX_W-1:0]             s5_bg_q;
  logic                         s5_warm_q;
  logic [PIX_W-1:0]             s5_diff;
  rabs_pkg::res_t               s5_res;

  logic                         st_we;
  logic [AW-1:0]                st_waddr;
  rabs_pkg::state_t             st_wdata;

  rabs_pkg::res_t               fifo_q [DEPTH];

  assign accept    = pix_i.valid && pix_i.ready;
  assign fifo_pop  = res_o.valid && res_o.ready;
  assign fifo_push = s5_valid_q;
  assign fifo_full = (fifo_cnt_q == OCC_W'(DEPTH));
  assign stage_vld = {s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q};

  // each accepted word owns one queue place until its result is taken
  assign pix_i.ready = !clr_busy_q && (occ_q < OCC_W'(DEPTH));
  assign res_o.valid = (fifo_cnt_q != '0);
  assign res_o.data  = fifo_q[rd_ptr_q];

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= rabs_pkg::THRESHOLD_RESET;
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
      frame_q     <= '0;
      slot_q      <= '0;
      base_q      <= '0;
      occ_q       <= '0;
      fifo_cnt_q  <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(NUM_PIXELS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      // frame count and ring slot move after the last word of a frame
      if (accept && pix_i.data.last_of_frame) begin
        if (frame_q < FC_W'(WINDOW + 1)) begin
          frame_q <= frame_q + FC_W'(1);
        end
        if (slot_q == SLOT_W'(WINDOW - 1)) begin
          slot_q <= '0;
          base_q <= '0;
        end else begin
          slot_q <= slot_q + SLOT_W'(1);
          base_q <= base_q + HAW'(NUM_PIXELS);
        end
      end
      case ({accept, fifo_pop})
        2'b10:   occ_q <= occ_q + OCC_W'(1);
        2'b01:   occ_q <= occ_q - OCC_W'(1);
        default: occ_q <= occ_q;
      endcase
      case ({fifo_push, fifo_pop})
        2'b10:   fifo_cnt_q <= fifo_cnt_q + OCC_W'(1);
        2'b01:   fifo_cnt_q <= fifo_cnt_q - OCC_W'(1);
        default: fifo_cnt_q <= fifo_cnt_q;
      endcase
      if (fifo_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (fifo_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      fwd_valid_q <= s4_valid_q;
    end
  end

  // ---------------------------------------------------------------- stage 1: quotient
  assign idx_prod = (IDX_W+IDX_RCP_W)'(pix_i.data.pixel_index) *
                    (IDX_W+IDX_RCP_W)'(IDX_RCP_W'(IDX_RCP));

  always_ff @(posedge clk_i) begin
    s1_val_q  <= pix_i.data.pixel_value;
    s1_idx_q  <= pix_i.data.pixel_index;
    s1_quo_q  <= IDX_W'(idx_prod >> IDX_SH);
    s1_warm_q <= (frame_q < FC_W'(WINDOW));
    s1_bgwr_q <= (frame_q == FC_W'(WINDOW));
    s1_base_q <= base_q;
  end

  // ---------------------------------------------------------------- stage 2: ram reads
  assign idx_rem   = s1_idx_q - IDX_W'(s1_quo_q * IDX_W'(NUM_PIXELS));
  assign hist_addr = s2_base_q + HAW'(s2_addr_q);

  always_ff @(posedge clk_i) begin
    s2_val_q  <= s1_val_q;
    s2_addr_q <= AW'(idx_rem);
    s2_warm_q <= s1_warm_q;
    s2_bgwr_q <= s1_bgwr_q;
    s2_base_q <= s1_base_q;
  end

  // history is read and overwritten in the same cycle; the read sees the old byte
  rabs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (HDEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (s2_valid_q),
    .waddr_i (hist_addr),
    .wdata_i (s2_val_q),
    .raddr_i (hist_addr),
    .rdata_o (hist_rdata)
  );

  assign st_we    = clr_busy_q || s4_valid_q;
  assign st_waddr = clr_busy_q ? clr_cnt_q : s4_addr_q;
  assign st_wdata = clr_busy_q ? rabs_pkg::state_t'('0) : s4_state;

  rabs_ram #(
    .WIDTH (STATE_W),
    .DEPTH (NUM_PIXELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (s2_addr_q),
    .rdata_o (state_rdata)
  );

  // ---------------------------------------------------------------- stage 3: sum update
  // the ram word misses the write of the word one ahead and the one two ahead
  always_comb begin
    if (s4_valid_q && (s4_addr_q == s3_addr_q)) begin
      s3_state = s4_state;
    end else if (fwd_valid_q && (fwd_addr_q == s3_addr_q)) begin
      s3_state = fwd_data_q;
    end else begin
      s3_state = state_rdata;
    end
  end

  assign s3_sum_new = s3_warm_q ? s3_state.sum + SUM_W'(s3_val_q)
                                : s3_state.sum + SUM_W'(s3_val_q) - SUM_W'(hist_rdata);

  always_ff @(posedge clk_i) begin
    s3_val_q  <= s2_val_q;
    s3_addr_q <= s2_addr_q;
    s3_warm_q <= s2_warm_q;
    s3_bgwr_q <= s2_bgwr_q;
    s4_sum_q  <= s3_sum_new;
    s4_bg_q   <= s3_state.bg;
    s4_addr_q <= s3_addr_q;
    s4_warm_q <= s3_warm_q;
    s4_bgwr_q <= s3_bgwr_q;
  end

  // ---------------------------------------------------------------- stage 4: mean, write back
  assign avg_prod = (SUM_W+AVG_RCP_W)'(s4_sum_q) * (SUM_W+AVG_RCP_W)'(AVG_RCP_W'(AVG_RCP));
  assign avg_full = SUM_W'(avg_prod >> AVG_SH);
  assign s4_avg   = s4_warm_q ? '0
                  : (avg_full > SUM_W'(rabs_pkg::PIX_MAX)) ? rabs_pkg::PIX_MAX
                  : PIX_W'(avg_full);

  assign s4_state.sum = s4_sum_q;
  assign s4_state.bg  = s4_bgwr_q ? s4_avg : s4_bg_q;

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= s4_addr_q;
    fwd_data_q <= s4_state;
    s5_avg_q   <= s4_avg;
    s5_bg_q    <= s4_state.bg;
    s5_warm_q  <= s4_warm_q;
  end

  // ---------------------------------------------------------------- stage 5: difference
  assign s5_diff = (s5_avg_q >= s5_bg_q) ? s5_avg_q - s5_bg_q : s5_bg_q - s5_avg_q;

  assign s5_res.average_value = s5_avg_q;
  assign s5_res.difference    = s5_diff;
  assign s5_res.foreground    = (s5_diff > thr_q);
  assign s5_res.warming_up    = s5_warm_q;

  always_ff @(posedge clk_i) begin
    if (fifo_push) begin
      fifo_q[wr_ptr_q] <= s5_res;
    end
  end

  // ---------------------------------------------------------------- checks
  `RABS_ASSERT(a_occ_track,
    int'(occ_q) == $countones(stage_vld) + int'(fifo_cnt_q),
    "occupancy count does not match words in flight")
  `RABS_ASSERT(a_fifo_room, (fifo_push && fifo_full) |-> fifo_pop, "result queue overflow")
  `RABS_ASSERT(a_clear_quiet,
    clr_busy_q |-> ((stage_vld == '0) && (occ_q == '0)),
    "word in flight during clearing pass")
  `RABS_ASSERT_NEXT(a_bg_latch, s4_valid_q && s4_bgwr_q, s5_avg_q == s5_bg_q,
    "background not latched from mean")

endmodule

// ===== tb/tb.sv =====
// self-checking bench for the running average background subtractor
module tb;

  localparam int PIX_W         = rabs_pkg::PIX_W;
  localparam int IDX_W         = rabs_pkg::IDX_W;
  localparam int SUM_W         = rabs_pkg::SUM_W;
  localparam int NUM_PX        = rabs_pkg::NUM_PIXELS_DEF;
  localparam int WIN           = rabs_pkg::WINDOW_DEF;
  localparam int LATENCY       = 6;
  localparam int SETTLE_CYCLES = LATENCY + 10;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int N_TRACKED     = 8;

  typedef struct packed {
    rabs_pkg::pix_t pix;
    rabs_pkg::res_t want;
  } stim_row_t;

  localparam rabs_pkg::res_t WARM_RES = '{average_value: '0, difference: '0,
                                          foreground: 1'b0, warming_up: 1'b1};

  // positions that appear in every warm-up frame so the history ring is filled before steady state
  localparam logic [IDX_W-1:0] TRACKED [N_TRACKED] = '{
    14'd0, 14'd16383, 14'd1, 14'd8192, 14'd5461, 14'd10922, 14'd4096, 14'd12287
  };

  // two warm-up frames: extremes, bit patterns, a repeated position and a stray one
  localparam stim_row_t DIRECTED_ROWS [18] = '{
    '{'{8'd0,   14'd0,     1'b0}, WARM_RES},
    '{'{8'd255, 14'd16383, 1'b0}, WARM_RES},
    '{'{8'd85,  14'd1,     1'b0}, WARM_RES},
    '{'{8'd170, 14'd8192,  1'b0}, WARM_RES},
    '{'{8'd128, 14'd5461,  1'b0}, WARM_RES},
    '{'{8'd127, 14'd10922, 1'b0}, WARM_RES},
    '{'{8'd1,   14'd4096,  1'b0}, WARM_RES},
    '{'{8'd254, 14'd12287, 1'b0}, WARM_RES},
    '{'{8'd255, 14'd0,     1'b1}, WARM_RES},
    '{'{8'd255, 14'd0,     1'b0}, WARM_RES},
    '{'{8'd0,   14'd16383, 1'b0}, WARM_RES},
    '{'{8'd170, 14'd1,     1'b0}, WARM_RES},
    '{'{8'd85,  14'd8192,  1'b0}, WARM_RES},
    '{'{8'd255, 14'd300,   1'b0}, WARM_RES},
    '{'{8'd0,   14'd5461,  1'b0}, WARM_RES},
    '{'{8'd255, 14'd10922, 1'b0}, WARM_RES},
    '{'{8'd0,   14'd4096,  1'b0}, WARM_RES},
    '{'{8'd128, 14'd12287, 1'b1}, WARM_RES}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [PIX_W-1:0] cfg_wdata;

  rabs_pix_if pix_if ();
  rabs_res_if res_if ();

  running_average_background_subtractor u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // mirror of the per-pixel state
  bit [PIX_W-1:0] ring_mem [NUM_PX*WIN];
  bit             ring_set [NUM_PX*WIN];
  bit [SUM_W-1:0] sum_mem  [NUM_PX];
  bit [PIX_W-1:0] bg_mem   [NUM_PX];
  int unsigned    frames_seen;
  int unsigned    ring_pos;
  bit [PIX_W-1:0] threshold = rabs_pkg::THRESHOLD_RESET;

  rabs_pkg::res_t pending_averages [$];
  bit [PIX_W-1:0] level [N_TRACKED];
  int unsigned    mismatch_count;
  int unsigned    cycle_count;
  int unsigned    items_sent;
  int unsigned    frame_no;
  bit             steady_flow;

  always #6 clk_i = ~clk_i;

  function automatic rabs_pkg::res_t step_background(rabs_pkg::pix_t w);
    int unsigned idx, slot, hpos, mean, bg, diff;
    bit warm;
    rabs_pkg::res_t r;
    idx  = 32'(w.pixel_index) % NUM_PX;
    slot = ring_pos % WIN;
    hpos = idx * WIN + slot;
    warm = frames_seen < WIN;
    mean = 0;
    if (warm) begin
      sum_mem[idx] = sum_mem[idx] + SUM_W'(w.pixel_value);
    end else begin
      // oldest word of the window drops out, sum wraps at 16 bits
      sum_mem[idx] = sum_mem[idx] + SUM_W'(w.pixel_value) - SUM_W'(ring_mem[hpos]);
      mean = 32'(sum_mem[idx]) / WIN;
      if (mean > 32'(rabs_pkg::PIX_MAX)) mean = 32'(rabs_pkg::PIX_MAX);
    end
    ring_mem[hpos] = w.pixel_value;
    ring_set[hpos] = 1'b1;
    if (frames_seen == WIN) bg_mem[idx] = mean[PIX_W-1:0];
    bg   = 32'(bg_mem[idx]);
    diff = (mean >= bg) ? mean - bg : bg - mean;
    r.average_value = mean[PIX_W-1:0];
    r.difference    = diff[PIX_W-1:0];
    r.foreground    = diff > 32'(threshold);
    r.warming_up    = warm;
    if (w.last_of_frame) begin
      if (frames_seen < WIN + 1) frames_seen++;
      ring_pos = (slot + 1) % WIN;
    end
    return r;
  endfunction

  // a steady-state word may only land on a ring entry that was written before
  function automatic bit history_known(logic [IDX_W-1:0] idx);
    return frames_seen < WIN || ring_set[32'(idx) * WIN + ring_pos];
  endfunction

  task automatic send_pixel(input rabs_pkg::pix_t w);
    @(negedge clk_i);
    while (!steady_flow && $urandom_range(99) < 30) begin
      pix_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.data  <= w;
    do @(posedge clk_i); while (!pix_if.ready);
  endtask

  task automatic set_threshold(input bit [PIX_W-1:0] thr);
    @(negedge clk_i);
    pix_if.valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= thr;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    threshold = thr;
  endtask

  task automatic run_frame();
    int unsigned order [N_TRACKED];
    int unsigned pick, tmp;
    int v;
    bit steady;
    rabs_pkg::pix_t w;
    rabs_pkg::pix_t words [$];
    steady = frames_seen >= WIN;
    for (int i = 0; i < N_TRACKED; i++) order[i] = i;
    for (int i = N_TRACKED - 1; i > 0; i--) begin
      pick = $urandom_range(i);
      tmp = order[i];
      order[i] = order[pick];
      order[pick] = tmp;
    end
    // occasional scene change so the mean drifts away from the background
    foreach (level[i]) begin
      if ($urandom_range(99) < 4) level[i] = PIX_W'($urandom_range(255));
    end
    foreach (order[i]) begin
      if ($urandom_range(99) < 12) begin
        w.pixel_index   = $urandom_range(1) ? TRACKED[$urandom_range(N_TRACKED - 1)]
                                            : IDX_W'($urandom_range(NUM_PX - 1));
        w.pixel_value   = PIX_W'($urandom_range(255));
        w.last_of_frame = 1'b0;
        if (history_known(w.pixel_index)) words.insert(words.size(), w);
      end
      // dropped positions only once the ring is full
      if (!(steady && $urandom_range(99) < 5) && history_known(TRACKED[order[i]])) begin
        if ($urandom_range(9) == 0) v = int'($urandom_range(255));
        else v = int'(level[order[i]]) + int'($urandom_range(16)) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        w.pixel_index   = TRACKED[order[i]];
        w.pixel_value   = v[PIX_W-1:0];
        w.last_of_frame = 1'b0;
        words.insert(words.size(), w);
      end
    end
    if (words.size() != 0) begin
      words[words.size()-1].last_of_frame = 1'b1;
      frame_no++;
    end
    foreach (words[i]) begin
      send_pixel(words[i]);
      pending_averages.insert(pending_averages.size(), step_background(words[i]));
      items_sent++;
    end
  endtask

  task automatic check_field(input string name, input logic [PIX_W-1:0] want,
                             input logic [PIX_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(negedge clk_i) res_if.ready <= steady_flow || ($urandom_range(99) >= 30);

  always @(posedge clk_i) begin : check_results
    rabs_pkg::res_t got, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (pending_averages.size() == 0) begin
        $error("result word with nothing expected: average_value %0d", got.average_value);
        mismatch_count++;
      end else begin
        want = pending_averages.pop_front();
        check_field("average_value", want.average_value, got.average_value);
        check_field("difference", want.difference, got.difference);
        check_field("foreground", PIX_W'(want.foreground), PIX_W'(got.foreground));
        check_field("warming_up", PIX_W'(want.warming_up), PIX_W'(got.warming_up));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    rabs_pkg::res_t discard;
    bit [PIX_W-1:0] thr_plan [6];
    pix_if.valid  = 1'b0;
    pix_if.data   = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    rst_ni        = 1'b0;
    thr_plan = '{8'd255, 8'd0, 8'd255, 8'($urandom_range(40)), 8'd50,
                 8'($urandom_range(255))};
    foreach (level[i]) level[i] = PIX_W'($urandom_range(255));
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      send_pixel(row.pix);
      discard = step_background(row.pix);
      pending_averages.insert(pending_averages.size(), row.want);
    end
    frame_no = 2;

    while (items_sent < RANDOM_ITEMS) begin
      if (frame_no % 30 == 0 && frame_no / 30 <= 6) set_threshold(thr_plan[frame_no/30 - 1]);
      steady_flow = frame_no >= 100 && frame_no < 116;
      run_frame();
    end

    @(negedge clk_i);
    pix_if.valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
